>>> rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants of the sorted priority queue
// Sizes, operation and status codes, controller states, command/status bundles.
// ----------------------------------------------------------------------------
package spq_pkg;

   localparam int DEPTH    = 16;
   localparam int VALUE_W  = 16;
   localparam int PRIO_W   = 16;
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int FUNC_W   = 2;
   localparam int STATUS_W = 3;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_ENQ = 2'd0,
      FUNC_DEQ = 2'd1,
      FUNC_CHG = 2'd2,
      FUNC_CLR = 2'd3
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK         = 3'd0,
      STATUS_EMPTY      = 3'd1,
      STATUS_NOT_FOUND  = 3'd2,
      STATUS_NOT_URGENT = 3'd3,
      STATUS_FULL       = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_REINSERT
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load_req;
      logic exec;
      logic reinsert;
      logic load_rsp;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic need_reinsert;
   } dp_stat_type;

endpackage

>>> rtl/spq_req_if.sv
// ----------------------------------------------------------------------------
// spq_req_if: request channel of the sorted priority queue
// Valid/ready channel carrying one operation per beat.
// ----------------------------------------------------------------------------
interface spq_req_if;
   logic                        valid;
   logic                        ready;
   logic [spq_pkg::FUNC_W-1:0]  func;
   logic [spq_pkg::VALUE_W-1:0] in_value;
   logic signed [spq_pkg::PRIO_W-1:0] in_priority;

   modport source (output valid, output func, output in_value, output in_priority,
                   input ready);
   modport sink   (input valid, input func, input in_value, input in_priority,
                   output ready);
endinterface

>>> rtl/spq_rsp_if.sv
// ----------------------------------------------------------------------------
// spq_rsp_if: response channel of the sorted priority queue
// Valid/ready channel carrying one result per beat.
// ----------------------------------------------------------------------------
interface spq_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [spq_pkg::STATUS_W-1:0]  status;
   logic [spq_pkg::VALUE_W-1:0]   out_value;
   logic signed [spq_pkg::PRIO_W-1:0] out_priority;
   logic [spq_pkg::CNT_W-1:0]     count;
   logic                          is_empty;

   modport source (output valid, output status, output out_value, output out_priority,
                   output count, output is_empty, input ready);
   modport sink   (input valid, input status, input out_value, input out_priority,
                   input count, input is_empty, output ready);
endinterface

>>> rtl/spq_ctrl.sv
// ----------------------------------------------------------------------------
// spq_ctrl: sequencing controller of the sorted priority queue
// Accepts a request, steps the datapath through execute and reinsert, and
// owns the response valid flag.
// ----------------------------------------------------------------------------
module spq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  spq_pkg::dp_stat_type dp_stat,
   output spq_pkg::cmd_type     cmd
);

   spq_pkg::state_type state_ff, state_in;
   logic pend_ff, pend_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic slot_free;
   logic publish;
   logic accept;
   logic finish;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         spq_pkg::S_IDLE: begin
            if (accept) begin
               state_in = spq_pkg::S_EXEC;
            end
         end
         spq_pkg::S_EXEC: begin
            if (dp_stat.need_reinsert) begin
               state_in = spq_pkg::S_REINSERT;
            end else begin
               state_in = spq_pkg::S_IDLE;
            end
         end
         spq_pkg::S_REINSERT: begin
            state_in = spq_pkg::S_IDLE;
         end
         default: begin
            state_in = spq_pkg::S_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_ready = 1'b0;
      publish   = 1'b0;
      finish    = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         spq_pkg::S_IDLE: begin
            publish   = pend_ff && slot_free;
            req_ready = !pend_ff || slot_free;
         end
         spq_pkg::S_EXEC: begin
            cmd.exec = 1'b1;
            finish   = !dp_stat.need_reinsert;
         end
         spq_pkg::S_REINSERT: begin
            cmd.reinsert = 1'b1;
            finish       = 1'b1;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
      accept       = req_valid && req_ready;
      cmd.load_req = accept;
      cmd.load_rsp = publish;
   end

   always_comb begin
      pend_in = pend_ff;
      if (finish) begin
         pend_in = 1'b1;
      end else if (publish) begin
         pend_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (publish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= spq_pkg::S_IDLE;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> rtl/spq_dpath.sv
// ----------------------------------------------------------------------------
// spq_dpath: datapath of the sorted priority queue
// A row of entry cells kept in priority order, with local compare and shift,
// the latched request and the response register.
// ----------------------------------------------------------------------------
module spq_dpath (
   input  logic                               clock,
   input  logic                               reset,
   input  spq_pkg::cmd_type                   cmd,
   output spq_pkg::dp_stat_type               dp_stat,
   input  logic [spq_pkg::FUNC_W-1:0]         req_func,
   input  logic [spq_pkg::VALUE_W-1:0]        req_value,
   input  logic signed [spq_pkg::PRIO_W-1:0]  req_priority,
   output logic [spq_pkg::STATUS_W-1:0]       rsp_status,
   output logic [spq_pkg::VALUE_W-1:0]        rsp_value,
   output logic signed [spq_pkg::PRIO_W-1:0]  rsp_priority,
   output logic [spq_pkg::CNT_W-1:0]          rsp_count,
   output logic                               rsp_is_empty
);

   localparam int D = spq_pkg::DEPTH;

   // latched request
   spq_pkg::func_type                  func_ff;
   logic [spq_pkg::VALUE_W-1:0]        rtag_ff;
   logic signed [spq_pkg::PRIO_W-1:0]  rprio_ff;

   // entry cells
   logic [spq_pkg::VALUE_W-1:0]        tag_ff  [D];
   logic [spq_pkg::VALUE_W-1:0]        tag_in  [D];
   logic signed [spq_pkg::PRIO_W-1:0]  prio_ff [D];
   logic signed [spq_pkg::PRIO_W-1:0]  prio_in [D];
   logic [spq_pkg::CNT_W-1:0]          count_ff, count_in;

   // per-operation results held until the response is published
   spq_pkg::status_type                status_ff, status_in;
   logic                               have_ff, have_in;
   logic [spq_pkg::VALUE_W-1:0]        held_tag_ff, held_tag_in;
   logic signed [spq_pkg::PRIO_W-1:0]  held_prio_ff, held_prio_in;

   // response register
   logic [spq_pkg::STATUS_W-1:0]       rsp_status_ff;
   logic [spq_pkg::VALUE_W-1:0]        rsp_value_ff;
   logic signed [spq_pkg::PRIO_W-1:0]  rsp_priority_ff;
   logic [spq_pkg::CNT_W-1:0]          rsp_count_ff;
   logic                               rsp_is_empty_ff;

   // cell-local compare results
   logic [D-1:0]                       occupied;
   logic [D-1:0]                       ge;
   logic [D-1:0]                       match;
   logic [D-1:0]                       first;
   logic [D-1:0]                       at_or_after;
   logic                               found;
   logic signed [spq_pkg::PRIO_W-1:0]  sel_prio;
   logic                               full;
   logic                               empty;
   logic [spq_pkg::VALUE_W-1:0]        ins_tag  [D];
   logic signed [spq_pkg::PRIO_W-1:0]  ins_prio [D];
   logic [spq_pkg::VALUE_W-1:0]        head_tag;
   logic signed [spq_pkg::PRIO_W-1:0]  head_prio;

   assign full  = (count_ff == spq_pkg::CNT_W'(D));
   assign empty = (count_ff == '0);

   always_comb begin
      for (int i = 0; i < D; i++) begin
         occupied[i] = (spq_pkg::CNT_W'(i) < count_ff);
         ge[i]       = occupied[i] && (rprio_ff >= prio_ff[i]);
         match[i]    = occupied[i] && (tag_ff[i] == rtag_ff);
      end
   end

   // isolate the matching entry nearest the head
   assign first       = match & (~match + D'(1));
   assign at_or_after = ~(first - D'(1));
   assign found       = |match;

   always_comb begin
      sel_prio = '0;
      for (int i = 0; i < D; i++) begin
         if (first[i]) begin
            sel_prio = sel_prio | prio_ff[i];
         end
      end
   end

   // sorted insert: keep cells that sort ahead, drop the new entry in the
   // first cell that does not, push the rest back by one
   always_comb begin
      ins_tag[0]  = ge[0] ? tag_ff[0]  : rtag_ff;
      ins_prio[0] = ge[0] ? prio_ff[0] : rprio_ff;
      for (int i = 1; i < D; i++) begin
         if (ge[i]) begin
            ins_tag[i]  = tag_ff[i];
            ins_prio[i] = prio_ff[i];
         end else if (ge[i-1]) begin
            ins_tag[i]  = rtag_ff;
            ins_prio[i] = rprio_ff;
         end else begin
            ins_tag[i]  = tag_ff[i-1];
            ins_prio[i] = prio_ff[i-1];
         end
      end
   end

   assign dp_stat.need_reinsert = cmd.exec && (func_ff == spq_pkg::FUNC_CHG) && found &&
                                  !(sel_prio < rprio_ff) && !first[0];

   always_comb begin
      tag_in       = tag_ff;
      prio_in      = prio_ff;
      count_in     = count_ff;
      status_in    = status_ff;
      have_in      = have_ff;
      held_tag_in  = held_tag_ff;
      held_prio_in = held_prio_ff;
      if (cmd.exec) begin
         status_in = spq_pkg::STATUS_OK;
         have_in   = 1'b0;
         unique case (func_ff)
            spq_pkg::FUNC_ENQ: begin
               if (full) begin
                  status_in = spq_pkg::STATUS_FULL;
               end else begin
                  tag_in   = ins_tag;
                  prio_in  = ins_prio;
                  count_in = count_ff + spq_pkg::CNT_W'(1);
               end
            end
            spq_pkg::FUNC_DEQ: begin
               have_in = 1'b1;
               if (empty) begin
                  status_in    = spq_pkg::STATUS_EMPTY;
                  held_tag_in  = '0;
                  held_prio_in = '0;
               end else begin
                  held_tag_in  = tag_ff[0];
                  held_prio_in = prio_ff[0];
                  for (int j = 0; j < D - 1; j++) begin
                     tag_in[j]  = tag_ff[j+1];
                     prio_in[j] = prio_ff[j+1];
                  end
                  count_in = count_ff - spq_pkg::CNT_W'(1);
               end
            end
            spq_pkg::FUNC_CHG: begin
               if (!found) begin
                  status_in = spq_pkg::STATUS_NOT_FOUND;
               end else if (sel_prio < rprio_ff) begin
                  status_in = spq_pkg::STATUS_NOT_URGENT;
               end else if (first[0]) begin
                  prio_in[0] = rprio_ff;
               end else begin
                  // close the gap; reinsertion follows next cycle
                  for (int j = 0; j < D - 1; j++) begin
                     if (at_or_after[j]) begin
                        tag_in[j]  = tag_ff[j+1];
                        prio_in[j] = prio_ff[j+1];
                     end
                  end
                  count_in = count_ff - spq_pkg::CNT_W'(1);
               end
            end
            spq_pkg::FUNC_CLR: begin
               count_in = '0;
            end
            default: begin
               status_in = spq_pkg::STATUS_OK;
            end
         endcase
      end else if (cmd.reinsert) begin
         tag_in   = ins_tag;
         prio_in  = ins_prio;
         count_in = count_ff + spq_pkg::CNT_W'(1);
      end
   end

   assign head_tag  = empty ? '0 : tag_ff[0];
   assign head_prio = empty ? '0 : prio_ff[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff       <= tag_in;
      prio_ff      <= prio_in;
      status_ff    <= status_in;
      have_ff      <= have_in;
      held_tag_ff  <= held_tag_in;
      held_prio_ff <= held_prio_in;
      if (cmd.load_req) begin
         func_ff  <= spq_pkg::func_type'(req_func);
         rtag_ff  <= req_value;
         rprio_ff <= req_priority;
      end
      if (cmd.load_rsp) begin
         rsp_status_ff   <= status_ff;
         rsp_value_ff    <= have_ff ? held_tag_ff  : head_tag;
         rsp_priority_ff <= have_ff ? held_prio_ff : head_prio;
         rsp_count_ff    <= count_ff;
         rsp_is_empty_ff <= empty;
      end
   end

   assign rsp_status   = rsp_status_ff;
   assign rsp_value    = rsp_value_ff;
   assign rsp_priority = rsp_priority_ff;
   assign rsp_count    = rsp_count_ff;
   assign rsp_is_empty = rsp_is_empty_ff;

endmodule

>>> rtl/sorted_priority_queue_core.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_core: bounded priority queue kept in sorted order
// Enqueue, dequeue, change priority by tag and clear, one result per request.
// ----------------------------------------------------------------------------
// The queue holds up to DEPTH entries in a row of cells kept in ascending
// priority order, equal priorities in arrival order, so the head is always the
// most urgent entry. Every request returns exactly one result beat: a status,
// the dequeued entry (or the head after the operation), and the fill level.
// After a request is accepted, one execute step follows in which every cell
// compares against the request and shifts locally, after which the next
// request can be accepted. A priority change that moves a non-head entry
// needs a reinsert step as well: the execute step closes the gap and a
// second step reinserts it. The response register publishes a finished
// result in the same cycle the next request is accepted; while it is still
// held by the sink and another result is pending, requests stall.
// ----------------------------------------------------------------------------
module sorted_priority_queue_core (
   input  logic        clock,
   input  logic        reset,
   spq_req_if.sink     req_chan,
   spq_rsp_if.source   rsp_chan
);

   spq_pkg::cmd_type     cmd;
   spq_pkg::dp_stat_type dp_stat;

   // sequencing: accept, execute, optional reinsert, publish
   spq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .dp_stat   (dp_stat),
      .cmd       (cmd)
   );

   // cell row, request latch and response register
   spq_dpath u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .dp_stat      (dp_stat),
      .req_func     (req_chan.func),
      .req_value    (req_chan.in_value),
      .req_priority (req_chan.in_priority),
      .rsp_status   (rsp_chan.status),
      .rsp_value    (rsp_chan.out_value),
      .rsp_priority (rsp_chan.out_priority),
      .rsp_count    (rsp_chan.count),
      .rsp_is_empty (rsp_chan.is_empty)
   );

   // an accepted beat is executed in the very next cycle
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && !reset) |=> cmd.exec)
      else $error("accepted beat not executed");

   // the fill level in a result never exceeds capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.count <= spq_pkg::CNT_W'(spq_pkg::DEPTH)))
      else $error("result count beyond capacity");

   // empty flag agrees with the count
   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.is_empty == (rsp_chan.count == '0)))
      else $error("is_empty disagrees with count");

   // full is only reported with a full queue
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.status == spq_pkg::STATUS_FULL))
      |-> (rsp_chan.count == spq_pkg::CNT_W'(spq_pkg::DEPTH)))
      else $error("full status with room left");

   // reinsertion only follows an execute step
   a_reinsert_order: assert property (@(posedge clock) disable iff (reset)
      cmd.reinsert |-> $past(cmd.exec))
      else $error("reinsert without execute");

endmodule
